// ===== hdl/integer_pixel_replication_scaler_assert.svh =====
// Assertion macros shared by the scaler RTL.
`ifndef INTEGER_PIXEL_REPLICATION_SCALER_ASSERT_SVH
`define INTEGER_PIXEL_REPLICATION_SCALER_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside reset.
`define IPRS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Condition in one cycle implies a consequence in the next one.
`define IPRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define IPRS_ASSERT(lbl, clk, rst, prop)
`define IPRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/iprs_pkg.sv =====
// Shared types and constants for the pixel replication scaler.
`timescale 1ns / 1ps

package iprs_pkg;

  // Configuration port
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

  localparam int SCALE_REG_W  = 7;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 11;

  // Source height limit and row counter width
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;

  localparam int PIXEL_W = 24;

  // Item kinds
  localparam logic KIND_SOURCE = 1'b0;
  localparam logic KIND_REPLAY = 1'b1;

  typedef enum logic {
    PHASE_SOURCE,
    PHASE_REPLAY
  } phase_t;

  // One decoded item on its way to the output
  typedef struct packed {
    logic               seq_error;
    logic               from_ram;
    logic               row_end;
    logic [1:0]         pad;
    logic               frame_end;
    logic [PIXEL_W-1:0] pixel;
  } item_t;

endpackage

// ===== hdl/iprs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module iprs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/integer_pixel_replication_scaler.sv =====
// Top level of the integer pixel replication scaler.
`timescale 1ns / 1ps
`include "integer_pixel_replication_scaler_assert.svh"

// Usage
//   Item channel (item_valid / item_stall): kind 0 carries a new source pixel,
//   kind 1 replays the next buffered pixel of the current row. Source rows and
//   their scale_factor - 1 replay rows must be sent in order.
//   Result channel (result_valid / result_stall): each item gives scale_factor
//   pixel results, one per cycle while result_stall is low; run_last marks
//   the last result of an item. An item of the wrong kind gives one result
//   with seq_error set. Each item passes through the decode register into
//   the single output register, which emits one pixel per cycle while
//   result_stall is low; one decoded item waits behind it, so items enter
//   back to back at factor 1 while results are not stalled. Source pixels
//   are written to a line store RAM (MAX_WIDTH x 24) at their column;
//   replays read it through its registered read port. The user makes
//   configuration writes (wr_en / wr_index / wr_data) only while idle; the
//   block does not enforce this. Reset clears the counters and phase, sets
//   the factor, width and height to one and empties the pipeline; the line
//   store is not cleared. A stalled result holds; the decoded item behind it
//   then fills and item_stall rises until the output register takes it.

module integer_pixel_replication_scaler #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              wr_en,
  input  logic [iprs_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [iprs_pkg::CFG_DATA_W-1:0]   wr_data,
  // items
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              kind,
  input  logic [7:0]                        blue,
  input  logic [7:0]                        green,
  input  logic [7:0]                        red,
  // results
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [7:0]                        out_blue,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_red,
  output logic                              row_end,
  output logic [1:0]                        pad_bytes,
  output logic                              frame_end,
  output logic                              run_last,
  output logic                              seq_error
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SFW = $clog2(MAX_SCALE + 1);
  localparam int RW  = iprs_pkg::ROW_W;

  // Configuration registers
  logic [iprs_pkg::SCALE_REG_W-1:0]  scale_factor;
  logic [iprs_pkg::WIDTH_REG_W-1:0]  source_width;
  logic [iprs_pkg::HEIGHT_REG_W-1:0] source_height;

  // Frame position
  logic [CW-1:0]        column_index;
  logic [RW-1:0]        source_row;
  logic [SFW-1:0]       repeat_row;
  iprs_pkg::phase_t     phase;

  // Decode stage and output stage
  logic                 s1_valid;
  iprs_pkg::item_t      s1_item;
  iprs_pkg::item_t      s1_item_next;
  logic [SFW-1:0]       s1_cnt;
  logic                 e_valid;
  iprs_pkg::item_t      e_item;
  iprs_pkg::item_t      e_item_next;
  logic [SFW-1:0]       e_cnt;

  logic [iprs_pkg::PIXEL_W-1:0] ram_rdata;

  // Effective (clamped) settings
  logic [7:0]           sf_ext;
  logic [SFW-1:0]       sf_eff;
  logic [14:0]          sw_ext;
  logic [CW:0]          sw_eff;
  logic [iprs_pkg::HEIGHT_REG_W-1:0] sh_eff;
  logic [3:0]           pad_prod;

  logic                 accept;
  logic                 kind_err;
  logic                 row_done;
  logic                 last_repeat;
  logic                 frame_done;
  logic                 e_last;
  logic                 e_adv;
  logic                 e_load;
  logic                 s1_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= iprs_pkg::SCALE_REG_W'(1);
      source_width  <= iprs_pkg::WIDTH_REG_W'(1);
      source_height <= iprs_pkg::HEIGHT_REG_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        iprs_pkg::REG_SCALE_FACTOR: begin
          scale_factor <= wr_data[iprs_pkg::SCALE_REG_W-1:0];
        end
        iprs_pkg::REG_SOURCE_WIDTH: begin
          source_width <= wr_data[iprs_pkg::WIDTH_REG_W-1:0];
        end
        iprs_pkg::REG_SOURCE_HEIGHT: begin
          source_height <= wr_data[iprs_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp settings to their legal ranges
  always_comb begin
    sf_ext = {1'b0, scale_factor};
    if (sf_ext == 8'd0) begin
      sf_eff = SFW'(1);
    end else if (sf_ext > 8'(MAX_SCALE)) begin
      sf_eff = SFW'(MAX_SCALE);
    end else begin
      sf_eff = SFW'(sf_ext);
    end

    sw_ext = 15'(source_width);
    if (sw_ext == 15'd0) begin
      sw_eff = (CW + 1)'(1);
    end else if (sw_ext > 15'(MAX_WIDTH)) begin
      sw_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      sw_eff = (CW + 1)'(sw_ext);
    end

    if (source_height == '0) begin
      sh_eff = iprs_pkg::HEIGHT_REG_W'(1);
    end else if (source_height > iprs_pkg::HEIGHT_REG_W'(iprs_pkg::MAX_HEIGHT)) begin
      sh_eff = iprs_pkg::HEIGHT_REG_W'(iprs_pkg::MAX_HEIGHT);
    end else begin
      sh_eff = source_height;
    end

    // output row width mod 4 only needs the low two bits of each factor
    pad_prod = 4'(2'(sw_eff)) * 4'(2'(sf_eff));
  end

  // Item decode
  always_comb begin
    s1_free  = !s1_valid || e_load;
    accept   = item_valid && s1_free;
    kind_err = (kind == iprs_pkg::KIND_REPLAY) != (phase == iprs_pkg::PHASE_REPLAY);
    row_done = ((CW + 1)'(column_index) + (CW + 1)'(1)) >= sw_eff;
    if (kind == iprs_pkg::KIND_SOURCE) begin
      last_repeat = (sf_eff == SFW'(1));
    end else begin
      last_repeat = ((SFW + 1)'(repeat_row) + (SFW + 1)'(1)) >= (SFW + 1)'(sf_eff);
    end
    frame_done = row_done && last_repeat &&
                 (((RW + 1)'(source_row) + (RW + 1)'(1)) >= (RW + 1)'(sh_eff));

    // Decoded item as it enters the decode register
    s1_item_next = '0;
    if (kind_err) begin
      s1_item_next.seq_error = 1'b1;
    end else begin
      s1_item_next.from_ram  = (kind == iprs_pkg::KIND_REPLAY);
      s1_item_next.row_end   = row_done;
      s1_item_next.pad       = row_done ? pad_prod[1:0] : 2'd0;
      s1_item_next.frame_end = frame_done;
      s1_item_next.pixel     = {red, green, blue};
    end
  end

  assign item_stall = !s1_free;

  // Line store: source pixels write, replays read
  iprs_ram #(
    .WIDTH (iprs_pkg::PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept && !kind_err && (kind == iprs_pkg::KIND_SOURCE)),
    .waddr (column_index),
    .wdata ({red, green, blue}),
    .re    (accept && !kind_err && (kind == iprs_pkg::KIND_REPLAY)),
    .raddr (column_index),
    .rdata (ram_rdata)
  );

  // Frame position update
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      source_row   <= '0;
      repeat_row   <= '0;
      phase        <= iprs_pkg::PHASE_SOURCE;
    end else if (accept && !kind_err) begin
      if (!row_done) begin
        column_index <= column_index + CW'(1);
      end else begin
        column_index <= '0;
        if (!last_repeat) begin
          repeat_row <= (kind == iprs_pkg::KIND_SOURCE) ? SFW'(1) : repeat_row + SFW'(1);
          phase      <= iprs_pkg::PHASE_REPLAY;
        end else begin
          repeat_row <= '0;
          phase      <= iprs_pkg::PHASE_SOURCE;
          source_row <= frame_done ? '0 : source_row + RW'(1);
        end
      end
    end
  end

  // Decode stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (e_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= s1_item_next;
      s1_cnt  <= kind_err ? SFW'(1) : sf_eff;
    end
  end

  // Output stage: repeats the pixel once per cycle while result_stall is low
  assign e_last = (e_cnt == SFW'(1));
  assign e_adv  = e_valid && !result_stall;
  assign e_load = !e_valid || (e_adv && e_last);

  // Replayed pixels take the line store read data
  always_comb begin
    e_item_next = s1_item;
    if (s1_item.from_ram) begin
      e_item_next.pixel = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_load) begin
      e_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_load && s1_valid) begin
      e_item <= e_item_next;
      e_cnt  <= s1_cnt;
    end else if (e_adv) begin
      e_cnt <= e_cnt - SFW'(1);
    end
  end

  // Result fields
  assign result_valid = e_valid;
  assign out_blue     = e_item.pixel[7:0];
  assign out_green    = e_item.pixel[15:8];
  assign out_red      = e_item.pixel[23:16];
  assign row_end      = e_last && e_item.row_end;
  assign pad_bytes    = e_last ? e_item.pad : 2'd0;
  assign frame_end    = e_last && e_item.frame_end;
  assign run_last     = e_last;
  assign seq_error    = e_item.seq_error;

  // Checks
  `IPRS_ASSERT(a_out_cnt_nonzero, clk, rst, !e_valid || (e_cnt != '0))
  `IPRS_ASSERT(a_err_single, clk, rst,
               !(result_valid && seq_error) || (run_last && !row_end && !frame_end))
  `IPRS_ASSERT(a_frame_on_row_end, clk, rst, !(result_valid && frame_end) || row_end)
  `IPRS_ASSERT(a_source_phase_no_repeat, clk, rst,
               (phase != iprs_pkg::PHASE_SOURCE) || (repeat_row == '0))
  `IPRS_ASSERT_NEXT(a_run_continues, clk, rst,
                    result_valid && !result_stall && !run_last, result_valid)

endmodule

// ===== dv/tb_integer_pixel_replication_scaler.sv =====
// Self-checking testbench for the integer pixel replication scaler.
`timescale 1ns / 1ps

module tb_integer_pixel_replication_scaler;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_SCALE    = 64;
  localparam int ITEM_TARGET  = 370;
  localparam int NOISE_PCT    = 10;
  localparam int IDLE_PCT     = 8;
  localparam int SETTLE_DELAY = 4;
  localparam int MAX_PRINTED  = 40;

  // One output pixel as seen on the result channel
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic [1:0] pad;
    logic       frame_end;
    logic       run_last;
    logic       seq_error;
  } pix_out_t;

  typedef enum logic {
    STEP_WRITE,
    STEP_ITEM
  } step_op_t;

  // One row of the directed script
  typedef struct packed {
    step_op_t                         op;
    logic [iprs_pkg::CFG_INDEX_W-1:0] index;
    logic [iprs_pkg::CFG_DATA_W-1:0]  value;
    logic                             k;
    logic [7:0]                       b;
    logic [7:0]                       g;
    logic [7:0]                       r;
    logic                             typed;
    pix_out_t                         want;
  } directed_step_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             wr_en = 1'b0;
  logic [iprs_pkg::CFG_INDEX_W-1:0] wr_index = '0;
  logic [iprs_pkg::CFG_DATA_W-1:0]  wr_data = '0;
  logic                             item_valid = 1'b0;
  logic                             item_stall;
  logic                             kind = iprs_pkg::KIND_SOURCE;
  logic [7:0]                       blue = '0;
  logic [7:0]                       green = '0;
  logic [7:0]                       red = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [7:0]                       out_blue;
  logic [7:0]                       out_green;
  logic [7:0]                       out_red;
  logic                             row_end;
  logic [1:0]                       pad_bytes;
  logic                             frame_end;
  logic                             run_last;
  logic                             seq_error;

  integer_pixel_replication_scaler #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the scaler state and registers
  logic [iprs_pkg::PIXEL_W-1:0]      line_copy [MAX_WIDTH];
  bit                                col_written [MAX_WIDTH];
  int unsigned                       col_idx = 0;
  int unsigned                       src_row = 0;
  int unsigned                       rep_row = 0;
  iprs_pkg::phase_t                  phase = iprs_pkg::PHASE_SOURCE;
  logic [iprs_pkg::SCALE_REG_W-1:0]  scale_reg = iprs_pkg::SCALE_REG_W'(1);
  logic [iprs_pkg::WIDTH_REG_W-1:0]  width_reg = iprs_pkg::WIDTH_REG_W'(1);
  logic [iprs_pkg::HEIGHT_REG_W-1:0] height_reg = iprs_pkg::HEIGHT_REG_W'(1);

  pix_out_t       pending_pixels[$];
  directed_step_t script[$];

  int items_sent = 0;
  int pixels_checked = 0;
  int kind_errors = 0;
  int frames_done = 0;
  int mismatches = 0;
  int gap_pct = IDLE_PCT;
  int stall_pct = IDLE_PCT;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Expected pixels for one accepted item; advances the shadow state
  function automatic void replicate_pixel(logic k, logic [7:0] b, logic [7:0] g,
                                          logic [7:0] r);
    int unsigned                  sf;
    int unsigned                  sw;
    int unsigned                  sh;
    logic [iprs_pkg::PIXEL_W-1:0] pix;
    bit                           row_done;
    bit                           last_rep;
    bit                           frame_done;
    pix_out_t                     res;
    sf = clamp_to(scale_reg, MAX_SCALE);
    sw = clamp_to(width_reg, MAX_WIDTH);
    sh = clamp_to(height_reg, iprs_pkg::MAX_HEIGHT);
    // wrong kind for the phase: lone error result, state untouched
    if (k != phase) begin
      res = '0;
      res.seq_error = 1'b1;
      res.run_last = 1'b1;
      pending_pixels.push_back(res);
      kind_errors++;
      return;
    end
    if (k == iprs_pkg::KIND_SOURCE) begin
      pix = {r, g, b};
      line_copy[col_idx] = pix;
      col_written[col_idx] = 1'b1;
    end else begin
      pix = line_copy[col_idx];
    end
    row_done = (col_idx + 1 >= sw);
    last_rep = (k == iprs_pkg::KIND_SOURCE) ? (sf <= 1) : (rep_row + 1 >= sf);
    frame_done = row_done && last_rep && (src_row + 1 >= sh);
    for (int unsigned n = 0; n < sf; n++) begin
      res = '0;
      {res.red, res.green, res.blue} = pix;
      // row and frame marks ride on the last copy only
      if (n + 1 == sf) begin
        res.row_end = row_done;
        res.pad = row_done ? 2'((sw * sf) % 4) : 2'd0;
        res.frame_end = frame_done;
        res.run_last = 1'b1;
      end
      pending_pixels.push_back(res);
    end
    if (!row_done) begin
      col_idx++;
    end else begin
      col_idx = 0;
      if (!last_rep) begin
        rep_row = (k == iprs_pkg::KIND_SOURCE) ? 1 : rep_row + 1;
        phase = iprs_pkg::PHASE_REPLAY;
      end else begin
        rep_row = 0;
        phase = iprs_pkg::PHASE_SOURCE;
        src_row = frame_done ? 0 : src_row + 1;
        if (frame_done) frames_done++;
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] wanted);
    if (got !== wanted)
      report_mismatch($sformatf("%s got %0h, want %0h (result %0d)", name, got, wanted,
                                pixels_checked));
  endtask

  // Result side: compare every transfer with the oldest expected pixel
  always @(posedge clk) begin : check_pixels
    pix_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        check_field("out_blue", out_blue, want.blue);
        check_field("out_green", out_green, want.green);
        check_field("out_red", out_red, want.red);
        check_field("row_end", 8'(row_end), 8'(want.row_end));
        check_field("pad_bytes", 8'(pad_bytes), 8'(want.pad));
        check_field("frame_end", 8'(frame_end), 8'(want.frame_end));
        check_field("run_last", 8'(run_last), 8'(want.run_last));
        check_field("seq_error", 8'(seq_error), 8'(want.seq_error));
      end
    end
  end

  // Random backpressure on the result channel
  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Send one item; prediction happens at the transfer edge
  task automatic send_item(logic k, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                           logic typed = 1'b0, pix_out_t want = '0);
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    blue <= b;
    green <= g;
    red <= r;
    do @(posedge clk); while (item_stall);
    replicate_pixel(k, b, g, r);
    // a typed-in row stands in for its single predicted pixel
    if (typed) begin
      void'(pending_pixels.pop_back());
      pending_pixels.push_back(want);
    end
    items_sent++;
  endtask

  // Hold the sender until every expected pixel has come out
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_DELAY) @(posedge clk);
  endtask

  task automatic write_reg(logic [iprs_pkg::CFG_INDEX_W-1:0] idx,
                           logic [iprs_pkg::CFG_DATA_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      iprs_pkg::REG_SCALE_FACTOR:  scale_reg = val[iprs_pkg::SCALE_REG_W-1:0];
      iprs_pkg::REG_SOURCE_WIDTH:  width_reg = val[iprs_pkg::WIDTH_REG_W-1:0];
      iprs_pkg::REG_SOURCE_HEIGHT: height_reg = val[iprs_pkg::HEIGHT_REG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic void plan_write(logic [iprs_pkg::CFG_INDEX_W-1:0] idx,
                                     logic [iprs_pkg::CFG_DATA_W-1:0] val);
    directed_step_t s;
    s = '0;
    s.op = STEP_WRITE;
    s.index = idx;
    s.value = val;
    script.push_back(s);
  endfunction

  function automatic void plan_item(logic k, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                    logic typed = 1'b0, pix_out_t want = '0);
    directed_step_t s;
    s = '0;
    s.op = STEP_ITEM;
    s.k = k;
    s.b = b;
    s.g = g;
    s.r = r;
    s.typed = typed;
    s.want = want;
    script.push_back(s);
  endfunction

  function automatic pix_out_t kind_error();
    pix_out_t p;
    p = '0;
    p.seq_error = 1'b1;
    p.run_last = 1'b1;
    return p;
  endfunction

  // Single pixel that closes its row
  function automatic pix_out_t lone_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                          logic [1:0] pad, logic last_in_frame);
    pix_out_t p;
    p = '0;
    {p.blue, p.green, p.red} = {b, g, r};
    p.row_end = 1'b1;
    p.pad = pad;
    p.frame_end = last_in_frame;
    p.run_last = 1'b1;
    return p;
  endfunction

  initial begin : stimulus
    logic        k;
    int          burst;
    int unsigned sf_val;
    int unsigned sw_val;
    int unsigned sh_val;

    // Reset-state frame: factor, width and height of one
    plan_item(iprs_pkg::KIND_REPLAY, 8'hFF, 8'hFF, 8'hFF, 1'b1, kind_error());
    plan_item(iprs_pkg::KIND_SOURCE, 8'hFF, 8'h00, 8'h00, 1'b1,
              lone_pixel(8'hFF, 8'h00, 8'h00, 2'd1, 1'b1));
    plan_item(iprs_pkg::KIND_SOURCE, 8'h00, 8'hFF, 8'h00, 1'b1,
              lone_pixel(8'h00, 8'hFF, 8'h00, 2'd1, 1'b1));
    plan_item(iprs_pkg::KIND_SOURCE, 8'h00, 8'h00, 8'hFF, 1'b1,
              lone_pixel(8'h00, 8'h00, 8'hFF, 2'd1, 1'b1));
    // zero registers act as one
    plan_write(iprs_pkg::REG_SCALE_FACTOR, 11'd0);
    plan_write(iprs_pkg::REG_SOURCE_WIDTH, 11'd0);
    plan_write(iprs_pkg::REG_SOURCE_HEIGHT, 11'd0);
    plan_item(iprs_pkg::KIND_SOURCE, 8'h5A, 8'hA5, 8'h3C, 1'b1,
              lone_pixel(8'h5A, 8'hA5, 8'h3C, 2'd1, 1'b1));
    // full 2x2 frame at factor three, with a source item during replay
    plan_write(iprs_pkg::REG_SCALE_FACTOR, 11'd3);
    plan_write(iprs_pkg::REG_SOURCE_WIDTH, 11'd2);
    plan_write(iprs_pkg::REG_SOURCE_HEIGHT, 11'd2);
    plan_item(iprs_pkg::KIND_SOURCE, 8'h11, 8'h22, 8'h33);
    plan_item(iprs_pkg::KIND_SOURCE, 8'h44, 8'h55, 8'h66);
    plan_item(iprs_pkg::KIND_SOURCE, 8'h00, 8'h00, 8'h00, 1'b1, kind_error());
    repeat (4) plan_item(iprs_pkg::KIND_REPLAY, 8'h00, 8'h00, 8'h00);
    plan_item(iprs_pkg::KIND_SOURCE, 8'h77, 8'h88, 8'h99);
    plan_item(iprs_pkg::KIND_SOURCE, 8'hAA, 8'hBB, 8'hCC);
    repeat (4) plan_item(iprs_pkg::KIND_REPLAY, 8'hFF, 8'hFF, 8'hFF);
    // factor above the cap, then lowered mid-frame to end the repeats early
    plan_write(iprs_pkg::REG_SCALE_FACTOR, 11'd127);
    plan_write(iprs_pkg::REG_SOURCE_WIDTH, 11'd1);
    plan_write(iprs_pkg::REG_SOURCE_HEIGHT, 11'd1);
    plan_item(iprs_pkg::KIND_SOURCE, 8'h00, 8'h00, 8'h00);
    plan_write(iprs_pkg::REG_SCALE_FACTOR, 11'd2);
    plan_item(iprs_pkg::KIND_REPLAY, 8'h00, 8'h00, 8'h00);
    // widest row and tallest image, cut short mid-frame
    plan_write(iprs_pkg::REG_SCALE_FACTOR, 11'd1);
    plan_write(iprs_pkg::REG_SOURCE_WIDTH, 11'd1024);
    plan_write(iprs_pkg::REG_SOURCE_HEIGHT, 11'd2047);
    plan_item(iprs_pkg::KIND_SOURCE, 8'hFF, 8'hFF, 8'hFF);
    plan_item(iprs_pkg::KIND_SOURCE, 8'h80, 8'h01, 8'h7F);
    plan_write(iprs_pkg::REG_SOURCE_WIDTH, 11'd1);
    plan_item(iprs_pkg::KIND_SOURCE, 8'h01, 8'h80, 8'hFE);
    plan_write(iprs_pkg::REG_SOURCE_HEIGHT, 11'd1);
    plan_item(iprs_pkg::KIND_SOURCE, 8'h7E, 8'h7F, 8'h80);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].op == STEP_WRITE) begin
        wait_idle();
        write_reg(script[i].index, script[i].value);
      end else begin
        send_item(script[i].k, script[i].b, script[i].g, script[i].r,
                  script[i].typed, script[i].want);
      end
    end

    // Random part: reconfigure while idle, then a burst of mostly well-formed items
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      case ($urandom_range(9))
        0:       sf_val = 0;
        1:       sf_val = $urandom_range(1) ? 64 : $urandom_range(127, 65);
        2:       sf_val = $urandom_range(16, 4);
        default: sf_val = $urandom_range(3, 1);
      endcase
      case ($urandom_range(9))
        0:       sw_val = 0;
        1:       sw_val = $urandom_range(2047);
        default: sw_val = $urandom_range(6, 1);
      endcase
      case ($urandom_range(9))
        0:       sh_val = 0;
        1:       sh_val = $urandom_range(2047);
        default: sh_val = $urandom_range(3, 1);
      endcase
      // large factors get short rows so frames still finish
      if (sf_val > 8 && sw_val > 2) sw_val = $urandom_range(2, 1);
      write_reg(iprs_pkg::REG_SCALE_FACTOR, iprs_pkg::CFG_DATA_W'(sf_val));
      write_reg(iprs_pkg::REG_SOURCE_WIDTH, iprs_pkg::CFG_DATA_W'(sw_val));
      write_reg(iprs_pkg::REG_SOURCE_HEIGHT, iprs_pkg::CFG_DATA_W'(sh_val));

      // one stretch of the run goes without any idling
      if (items_sent >= 150 && items_sent < 230) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = IDLE_PCT;
        stall_pct = IDLE_PCT;
      end

      burst = $urandom_range(40, 12);
      repeat (burst) begin
        k = (phase == iprs_pkg::PHASE_REPLAY) ? iprs_pkg::KIND_REPLAY : iprs_pkg::KIND_SOURCE;
        if ($urandom_range(99) < NOISE_PCT) k = ~k;
        // never replay a column that holds no pixel yet
        if (k == iprs_pkg::KIND_REPLAY && phase == iprs_pkg::PHASE_REPLAY &&
            !col_written[col_idx])
          k = iprs_pkg::KIND_SOURCE;
        send_item(k, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d expected pixels never came", pending_pixels.size()));
    $display("Sent %0d items, checked %0d pixels, %0d wrong-kind items, %0d frames done.",
             items_sent, pixels_checked, kind_errors, frames_done);
    $display("Covered clamped registers, factor cap, mid-frame changes and backpressure.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Timeout with %0d pixels outstanding", pending_pixels.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== integer_pixel_replication_scaler.f =====
+incdir+hdl
hdl/iprs_pkg.sv
hdl/iprs_ram.sv
hdl/integer_pixel_replication_scaler.sv
dv/tb_integer_pixel_replication_scaler.sv
